>>> design/assert_macros.svh
// Assertion macros used by the checker file of the divider.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define SSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ssd_pkg.sv
// Package of the signed shift-subtract divider: widths, status codes and the
// command and status structs between controller and datapath. No dependencies.
package ssd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W = $clog2(DATA_WIDTH);

	localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ssd_cmd_t;

	typedef struct packed {
		logic last;
	} ssd_stat_t;

endpackage

>>> design/ssd_in_if.sv
// Input channel of the divider: valid/ready handshake carrying one operand word.
// Depends on ssd_pkg for the data width.
interface ssd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ssd_pkg::DATA_WIDTH-1:0] numerator;
	logic signed [ssd_pkg::DATA_WIDTH-1:0] denominator;

	modport source (output valid, output numerator, output denominator, input ready);
	modport sink (input valid, input numerator, input denominator, output ready);
endinterface

>>> design/ssd_out_if.sv
// Output channel of the divider: valid/ready handshake carrying one result word.
// Depends on ssd_pkg for the data width.
interface ssd_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ssd_pkg::DATA_WIDTH-1:0] quotient_out;
	logic [1:0]                          status;

	modport source (output valid, output quotient_out, output status, input ready);
	modport sink (input valid, input quotient_out, input status, output ready);
endinterface

>>> design/ssd_datapath.sv
// Datapath of the divider: operand magnitudes, restoring shift-subtract step,
// bit counter and the result register. Depends on ssd_pkg.
module ssd_datapath (
	input  logic                                  clk,
	input  ssd_pkg::ssd_cmd_t                     cmd,
	output ssd_pkg::ssd_stat_t                    stat,
	input  logic signed [ssd_pkg::DATA_WIDTH-1:0] numerator,
	input  logic signed [ssd_pkg::DATA_WIDTH-1:0] denominator,
	output logic signed [ssd_pkg::DATA_WIDTH-1:0] quotient_out,
	output logic [1:0]                            status
);
	import ssd_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W-1:0]     den_q;
	logic [W-1:0]     dvd_q;
	logic [W-2:0]     rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             div0_q;
	logic [W-1:0]     res_q;
	logic [1:0]       st_q;

	logic [W-1:0] num_mag;
	logic [W-1:0] den_mag;
	logic [W-1:0] shifted;
	logic [W:0]   diff;
	logic         fits;

	assign num_mag = numerator[W-1] ? (~numerator + 1'b1) : numerator;
	assign den_mag = denominator[W-1] ? (~denominator + 1'b1) : denominator;

	// Bring the next dividend bit into the partial remainder and try the divisor.
	assign shifted = {rem_q, dvd_q[W-1]};
	assign diff    = {1'b0, shifted} - {1'b0, den_q};
	assign fits    = ~diff[W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q  <= num_mag;
			den_q  <= den_mag;
			rem_q  <= '0;
			cnt_q  <= CNT_W'(W - 1);
			neg_q  <= numerator[W-1] ^ denominator[W-1];
			div0_q <= (denominator == '0);
		end else if (cmd.step) begin
			rem_q <= fits ? diff[W-2:0] : shifted[W-2:0];
			dvd_q <= {dvd_q[W-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The quotient bits have replaced the dividend in dvd_q at this point.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (div0_q) begin
				res_q <= MAX_POS;
				st_q  <= ST_DIV0;
			end else if (!neg_q && dvd_q[W-1]) begin
				res_q <= MAX_POS;
				st_q  <= ST_OVF;
			end else begin
				res_q <= neg_q ? (~dvd_q + 1'b1) : dvd_q;
				st_q  <= ST_OK;
			end
		end
	end

	assign stat.last    = (cnt_q == '0);
	assign quotient_out = res_q;
	assign status       = st_q;

endmodule

>>> design/ssd_controller.sv
// Controller of the divider: sequences load, the per-bit steps and the result
// write, and owns both handshakes. Depends on ssd_pkg.
module ssd_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ssd_pkg::ssd_cmd_t  cmd,
	input  ssd_pkg::ssd_stat_t stat
);
	import ssd_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       can_write;

	assign can_write = ~out_valid_q | out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (can_write) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/signed_shift_subtract_divider.sv
// Top level of the signed 32-bit restoring divider: controller plus datapath.
// Depends on ssd_pkg, ssd_in_if, ssd_out_if, ssd_controller and ssd_datapath.
//
//   channel   direction  word fields
//   div_in    sink       numerator[31:0] signed, denominator[31:0] signed
//   div_out   source     quotient_out[31:0] signed, status[1:0]
//
// A word goes from acceptance to a valid result in steps: the accepting edge
// loads the magnitudes, then one step per quotient bit in the shared
// subtract-and-compare unit, and a final write applies the sign and the
// saturation into the output register; that write waits while the output
// register holds an unaccepted result. The input is ready again once the write
// is done, so a new word is not taken before the last one has been written.
// Reset is asynchronous and active low; it clears the controller state and the
// output valid flag only.
// A result that waits on the output does not block the next input word; a new
// result waits in the final state until the output register is free.
module signed_shift_subtract_divider (
	input  logic      clk,
	input  logic      arst_n,
	ssd_in_if.sink    div_in,
	ssd_out_if.source div_out
);
	import ssd_pkg::*;

	ssd_cmd_t  cmd;
	ssd_stat_t stat;

	// The controller decides when to load, step and write the result; it
	// never looks at the payload.
	ssd_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_in.valid),
		.in_ready  (div_in.ready),
		.out_valid (div_out.valid),
		.out_ready (div_out.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// The datapath holds the operands, the partial remainder and the quotient,
	// which shifts into the register that held the dividend.
	ssd_datapath u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (stat),
		.numerator    (div_in.numerator),
		.denominator  (div_in.denominator),
		.quotient_out (div_out.quotient_out),
		.status       (div_out.status)
	);

endmodule

>>> design/ssd_checker.sv
// Port-level checker for the divider and the bind that attaches it.
// Depends on ssd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssd_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [ssd_pkg::DATA_WIDTH-1:0] quotient_out,
	input logic [1:0]                            status
);
	import ssd_pkg::*;

	// Only the three defined status codes ever appear.
	`SSD_ASSERT_IMPL(a_status_code, clk, arst_n, out_valid, status != 2'd3, "bad status code")

	// Divide by zero and overflow both report the largest positive value.
	`SSD_ASSERT_IMPL(a_sat_value, clk, arst_n, out_valid && (status != ST_OK), quotient_out == MAX_POS, "saturated result is not the largest positive value")

	// The divider is busy right after taking a word.
	`SSD_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "input ready right after acceptance")

	// No result can appear the cycle after a word is taken.
	`SSD_ASSERT_NEXT(a_no_early, clk, arst_n, in_valid && in_ready, !$rose(out_valid), "result appeared too early")

	// A stalled result holds.
	`SSD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(quotient_out) && $stable(status), "stalled result changed")

endmodule

bind signed_shift_subtract_divider ssd_checker u_ssd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (div_in.valid),
	.in_ready     (div_in.ready),
	.out_valid    (div_out.valid),
	.out_ready    (div_out.ready),
	.quotient_out (div_out.quotient_out),
	.status       (div_out.status)
);
